>>> rtl/gmte_pkg.sv
// shared types, constants and helper functions for the move time estimator
package gmte_pkg;

    localparam int unsigned POS_W       = 32;
    localparam int unsigned FEED_W      = 31;
    localparam int unsigned TOTAL_W     = 48;
    localparam int unsigned FRAC_BITS   = 12;
    localparam int unsigned SQRT_STEPS  = 32;
    localparam int unsigned DIV_STEPS   = POS_W + FRAC_BITS;
    localparam int unsigned ITER_CNT_W  = 6;
    localparam int unsigned MUL_CNT_W   = 3;
    localparam int unsigned MUL_LAST    = 4;

    // floor(x / 60) == (x * RECIP60) >> RECIP_SHIFT for every 31 bit x
    localparam logic [31:0] RECIP60     = 32'd2290649225;
    localparam int unsigned RECIP_SHIFT = 37;

    localparam logic [FEED_W-1:0] FEED_RESET = 31'd102400;

    typedef enum logic [1:0] {
        CMD_MOVE       = 2'd0,
        CMD_SET_ORIGIN = 2'd1,
        CMD_ABS_EXTR   = 2'd2,
        CMD_REL_EXTR   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POS,
        ST_DIFF,
        ST_MUL,
        ST_SQRT,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef enum logic {
        OP_SQRT,
        OP_DIV
    } t_iter_op;

    typedef struct packed {
        logic     start;
        t_iter_op op;
    } t_iter_req;

    // clamp a 33 bit signed difference to the signed 32 bit range
    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        logic signed [31:0] res;
        if (v[32] != v[31]) begin
            res = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // magnitude of the difference of two signed 32 bit values
    function automatic logic [31:0] abs_diff(input logic signed [31:0] a,
                                             input logic signed [31:0] b);
        logic signed [32:0] d;
        logic [32:0]        m;
        d = {a[31], a} - {b[31], b};
        m = d[32] ? 33'(-d) : 33'(d);
        return m[31:0];
    endfunction

endpackage

>>> rtl/gmte_iter.sv
// shared shift and subtract unit: integer square root and unsigned division
module gmte_iter (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  gmte_pkg::t_iter_req  i_req,
    input  logic [63:0]          i_radicand,
    input  logic [43:0]          i_dividend,
    input  logic [30:0]          i_divisor,
    output logic                 o_done,
    output logic [31:0]          o_root,
    output logic [43:0]          o_quot
);
    import gmte_pkg::*;

    logic                   r_busy;
    logic                   r_done;
    t_iter_op               r_op;
    logic [ITER_CNT_W-1:0]  r_cnt;
    logic [32:0]            r_rem;
    logic [63:0]            r_src;
    logic [31:0]            r_root;
    logic [FEED_W-1:0]      r_div;

    logic [34:0]            op_a;
    logic [34:0]            op_b;
    logic [35:0]            diff;
    logic                   ge;
    logic [ITER_CNT_W-1:0]  last;

    // one subtractor serves both recurrences
    always_comb begin
        if (r_op == OP_SQRT) begin
            op_a = {r_rem, r_src[63:62]};
            op_b = {1'b0, r_root, 2'b01};
            last = ITER_CNT_W'(SQRT_STEPS - 1);
        end else begin
            op_a = {2'b00, r_rem[31:0], r_src[63]};
            op_b = {4'b0000, r_div};
            last = ITER_CNT_W'(DIV_STEPS - 1);
        end
        diff = {1'b0, op_a} - {1'b0, op_b};
        ge   = ~diff[35];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= OP_SQRT;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_op   <= i_req.op;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= '0;
            r_root <= '0;
            r_div  <= i_divisor;
            if (i_req.op == OP_SQRT) begin
                r_src <= i_radicand;
            end else begin
                r_src <= {i_dividend, {(64 - DIV_STEPS){1'b0}}};
            end
        end else if (r_busy) begin
            r_rem <= ge ? diff[32:0] : op_a[32:0];
            if (r_op == OP_SQRT) begin
                r_root <= {r_root[30:0], ge};
                r_src  <= {r_src[61:0], 2'b00};
            end else begin
                // quotient bits fill in from the bottom as dividend bits leave
                r_src  <= {r_src[62:0], ge};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
    assign o_quot = r_src[DIV_STEPS-1:0];

endmodule

>>> rtl/gcode_move_time_estimator.sv
// top level: command sequencer, machine state, multiplier and running totals
// a move passes through position update, difference, multiply, root, divide and write-back;
//   the divide is skipped with a zero feed
// set origin and extrusion mode commands give no result
// no new command is accepted while a move is in progress, up to its write-back;
//   a result still held on the output stalls the write-back
// synchronous active-low reset clears origins, position, totals and mode; feed to 25 mm/s
module gcode_move_time_estimator (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration: default feed rate
    input  logic                 i_cfg_wr_en,
    input  logic [30:0]          i_cfg_wr_data,
    // command channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_command,
    input  logic                 i_has_x,
    input  logic                 i_has_y,
    input  logic                 i_has_z,
    input  logic                 i_has_e,
    input  logic                 i_has_f,
    input  logic signed [31:0]   i_x_value,
    input  logic signed [31:0]   i_y_value,
    input  logic signed [31:0]   i_z_value,
    input  logic signed [31:0]   i_e_value,
    input  logic [30:0]          i_f_value,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [31:0]          o_distance,
    output logic [31:0]          o_duration,
    output logic [47:0]          o_start_time,
    output logic [47:0]          o_end_time,
    output logic signed [31:0]   o_extruded,
    output logic [47:0]          o_total_distance_out,
    output logic signed [47:0]   o_total_extruded_out,
    output logic                 o_zero_feed
);
    import gmte_pkg::*;

    // sequencer
    t_state                 r_state;
    t_state                 n_state;
    logic [MUL_CNT_W-1:0]   r_cnt;

    // machine state, kept across transactions
    logic signed [31:0]     r_origin [4];
    logic signed [31:0]     r_pos    [3];
    logic [FEED_W-1:0]      r_feed;
    logic                   r_feed_seen;
    logic                   r_rel;
    logic [TOTAL_W-1:0]     r_total_time;
    logic [TOTAL_W-1:0]     r_total_dist;
    logic signed [TOTAL_W-1:0] r_total_ext;

    // per-move working registers
    logic [4:0]             r_has;      // x, y, z, e, f
    logic signed [31:0]     r_word [4];
    logic [FEED_W-1:0]      r_fval;
    logic [31:0]            r_d    [3];
    logic signed [31:0]     r_ext;
    logic [63:0]            r_prod;
    logic [63:0]            r_sum;
    logic                   r_carry;
    logic [31:0]            r_dist;
    logic [31:0]            r_dur;
    logic                   r_zf;

    // output register
    logic                   r_out_valid;
    logic [31:0]            r_o_dist;
    logic [31:0]            r_o_dur;
    logic [TOTAL_W-1:0]     r_o_start;
    logic [TOTAL_W-1:0]     r_o_end;
    logic signed [31:0]     r_o_ext;
    logic [TOTAL_W-1:0]     r_o_tdist;
    logic signed [TOTAL_W-1:0] r_o_text;
    logic                   r_o_zf;

    logic                   in_acc;
    logic                   out_free;
    logic                   wb_en;
    t_iter_req              iter_req;
    logic                   iter_done;
    logic [31:0]            iter_root;
    logic [DIV_STEPS-1:0]   iter_quot;
    logic [31:0]            dist_val;
    logic [31:0]            mul_a;
    logic [31:0]            mul_b;
    logic [63:0]            mul_p;
    logic [64:0]            acc_sum;
    logic [TOTAL_W:0]       tt_sum;
    logic [TOTAL_W:0]       td_sum;
    logic signed [TOTAL_W:0] te_sum;
    logic [TOTAL_W-1:0]     tt_new;
    logic [TOTAL_W-1:0]     td_new;
    logic signed [TOTAL_W-1:0] te_new;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // a sum of squares that overflows 64 bits saturates the length
    assign dist_val = r_carry ? 32'hFFFF_FFFF : iter_root;

    gmte_iter u_iter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (iter_req),
        .i_radicand (r_sum),
        .i_dividend ({dist_val, {FRAC_BITS{1'b0}}}),
        .i_divisor  (r_feed),
        .o_done     (iter_done),
        .o_root     (iter_root),
        .o_quot     (iter_quot)
    );

    // next state and unit control
    always_comb begin
        n_state    = r_state;
        iter_req   = '{start: 1'b0, op: OP_SQRT};
        o_in_ready = 1'b0;
        wb_en      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (in_acc && t_cmd'(i_command) == CMD_MOVE) begin
                    n_state = ST_POS;
                end
            end
            ST_POS:  n_state = ST_DIFF;
            ST_DIFF: n_state = ST_MUL;
            ST_MUL: begin
                if (r_cnt == MUL_CNT_W'(MUL_LAST)) begin
                    iter_req = '{start: 1'b1, op: OP_SQRT};
                    n_state  = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (iter_done) begin
                    if (r_feed == '0) begin
                        n_state = ST_DONE;
                    end else begin
                        iter_req = '{start: 1'b1, op: OP_DIV};
                        n_state  = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (iter_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    wb_en   = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // shared multiplier: three squares, then the feed reciprocal
    always_comb begin
        case (r_cnt)
            3'd0:    begin mul_a = r_d[0]; mul_b = r_d[0]; end
            3'd1:    begin mul_a = r_d[1]; mul_b = r_d[1]; end
            3'd2:    begin mul_a = r_d[2]; mul_b = r_d[2]; end
            default: begin mul_a = {1'b0, r_fval}; mul_b = RECIP60; end
        endcase
        mul_p   = mul_a * mul_b;
        acc_sum = {1'b0, r_sum} + {1'b0, r_prod};
    end

    // saturating running totals
    always_comb begin
        tt_sum = {1'b0, r_total_time} + (TOTAL_W + 1)'(r_dur);
        td_sum = {1'b0, r_total_dist} + (TOTAL_W + 1)'(r_dist);
        te_sum = {r_total_ext[TOTAL_W-1], r_total_ext}
               + {{(TOTAL_W + 1 - 32){r_ext[31]}}, r_ext};
        tt_new = tt_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : tt_sum[TOTAL_W-1:0];
        td_new = td_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : td_sum[TOTAL_W-1:0];
        if (te_sum[TOTAL_W] != te_sum[TOTAL_W-1]) begin
            te_new = te_sum[TOTAL_W] ? {1'b1, {(TOTAL_W - 1){1'b0}}}
                                     : {1'b0, {(TOTAL_W - 1){1'b1}}};
        end else begin
            te_new = te_sum[TOTAL_W-1:0];
        end
    end

    // machine state and control counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) r_origin[i] <= '0;
            for (int i = 0; i < 3; i++) r_pos[i] <= '0;
            r_feed       <= FEED_RESET;
            r_feed_seen  <= 1'b0;
            r_rel        <= 1'b0;
            r_total_time <= '0;
            r_total_dist <= '0;
            r_total_ext  <= '0;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            // the default feed only counts until the first F word
            if (i_cfg_wr_en && !r_feed_seen) begin
                r_feed <= i_cfg_wr_data;
            end

            if (in_acc) begin
                unique case (t_cmd'(i_command))
                    CMD_SET_ORIGIN: begin
                        if (i_has_x) r_origin[0] <= i_x_value;
                        if (i_has_y) r_origin[1] <= i_y_value;
                        if (i_has_z) r_origin[2] <= i_z_value;
                        if (i_has_e) r_origin[3] <= i_e_value;
                    end
                    CMD_ABS_EXTR: r_rel <= 1'b0;
                    CMD_REL_EXTR: r_rel <= 1'b1;
                    CMD_MOVE:     ;
                    default:      ;
                endcase
            end

            if (r_state == ST_POS) begin
                for (int i = 0; i < 3; i++) begin
                    if (r_has[i]) begin
                        r_pos[i] <= sat32({r_word[i][31], r_word[i]}
                                          - {r_origin[i][31], r_origin[i]});
                    end
                end
            end

            if (r_state == ST_DIFF) begin
                r_cnt <= '0;
            end else if (r_state == ST_MUL) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MUL_CNT_W'(MUL_LAST) && r_has[4]) begin
                    r_feed      <= FEED_W'(r_prod[63:RECIP_SHIFT]);
                    r_feed_seen <= 1'b1;
                end
            end

            if (wb_en) begin
                r_total_time <= tt_new;
                r_total_dist <= td_new;
                r_total_ext  <= te_new;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    // per-move datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_has     <= {i_has_f, i_has_e, i_has_z, i_has_y, i_has_x};
            r_word[0] <= i_x_value;
            r_word[1] <= i_y_value;
            r_word[2] <= i_z_value;
            r_word[3] <= i_e_value;
            r_fval    <= i_f_value;
        end

        unique case (r_state)
            ST_POS: begin
                // keep the old position for the difference step
                for (int i = 0; i < 3; i++) r_d[i] <= r_pos[i];
                if (!r_has[3]) begin
                    r_ext <= '0;
                end else if (r_rel) begin
                    r_ext <= r_word[3];
                end else begin
                    r_ext <= sat32({r_word[3][31], r_word[3]}
                                   - {r_origin[3][31], r_origin[3]});
                end
            end
            ST_DIFF: begin
                for (int i = 0; i < 3; i++) r_d[i] <= abs_diff(r_pos[i], r_d[i]);
            end
            ST_MUL: begin
                r_prod <= mul_p;
                if (r_cnt == 3'd1) begin
                    r_sum   <= r_prod;
                    r_carry <= 1'b0;
                end else if (r_cnt == 3'd2 || r_cnt == 3'd3) begin
                    r_sum   <= acc_sum[63:0];
                    r_carry <= r_carry | acc_sum[64];
                end
            end
            ST_SQRT: begin
                if (iter_done) begin
                    r_dist <= dist_val;
                    r_dur  <= 32'hFFFF_FFFF;
                    r_zf   <= (r_feed == '0);
                end
            end
            ST_DIV: begin
                if (iter_done) begin
                    r_dur <= (iter_quot[DIV_STEPS-1:32] != '0) ? 32'hFFFF_FFFF
                                                               : iter_quot[31:0];
                end
            end
            ST_IDLE, ST_DONE: ;
            default: ;
        endcase

        if (wb_en) begin
            r_o_dist  <= r_dist;
            r_o_dur   <= r_dur;
            r_o_start <= r_total_time;
            r_o_end   <= tt_new;
            r_o_ext   <= r_ext;
            r_o_tdist <= td_new;
            r_o_text  <= te_new;
            r_o_zf    <= r_zf;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_distance           = r_o_dist;
    assign o_duration           = r_o_dur;
    assign o_start_time         = r_o_start;
    assign o_end_time           = r_o_end;
    assign o_extruded           = r_o_ext;
    assign o_total_distance_out = r_o_tdist;
    assign o_total_extruded_out = r_o_text;
    assign o_zero_feed          = r_o_zf;

`ifndef ASSERT_OFF
    // the root and divide unit only finishes while the sequencer waits for it
    a_iter_done_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        iter_done |-> (r_state == ST_SQRT || r_state == ST_DIV))
        else $error("iterative unit finished outside a wait state");

    // a zero feed always comes with a saturated duration
    a_zero_feed_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_zero_feed) |-> (o_duration == 32'hFFFF_FFFF))
        else $error("zero feed without saturated duration");

    // end time never precedes start time
    a_time_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_end_time >= o_start_time))
        else $error("end time before start time");

    // accumulated time only grows between resets
    a_time_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_total_time >= $past(r_total_time)))
        else $error("total time decreased");
`endif

endmodule
